// ----- rtl/rotation_matrix_to_quaternion_macros.svh -----
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define RMQ_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rmq assertion failed");
// Next-cycle implication, checked outside reset.
`define RMQ_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_NOW(lbl, ant, cons)
`define RMQ_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ----- rtl/rmq_pkg.sv -----
// Shared constants for the rotation matrix to quaternion block.
package rmq_pkg;
  localparam int WORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Branch codes reported with each result.
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_COL0  = 2'd1;
  localparam logic [1:0] BR_COL1  = 2'd2;
  localparam logic [1:0] BR_COL2  = 2'd3;
endpackage

// ----- rtl/rmq_if.sv -----
// Valid/ready channel interfaces for matrices in and quaternions out.
interface rmq_in_if #(parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22;
  modport source (output valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                  input ready);
  modport sink (input valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                output ready);
endinterface

interface rmq_out_if #(parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] q_x, q_y, q_z, q_w;
  logic [1:0]                  branch_taken;
  logic                        degenerate;
  modport source (output valid, q_x, q_y, q_z, q_w, branch_taken, degenerate,
                  input ready);
  modport sink (input valid, q_x, q_y, q_z, q_w, branch_taken, degenerate,
                output ready);
endinterface

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Pipelined rotation matrix to quaternion converter, Shepperd branch selection.
// The pipeline has a front stage, RW = (AW+FRAC_BITS+1)/2 square root stages and
// NW = WORD_BITS+1+FRAC_BITS divider stages, then an output register. Throughput:
// one transaction per cycle while the output register is not stalled; the
// square root and the three restoring dividers retire one bit per stage.
// Reset: synchronous active-low rst_n clears every valid bit; payload is not reset.
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion #(
  parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int AW = ((W > F + 1) ? W : F + 1) + 3;
  localparam int RW = (AW + F + 1) / 2;
  localparam int SW = 2 * RW;
  localparam int SR = RW + 2;
  localparam int NW = W + 1 + F;
  localparam int DR = RW + 2;
  localparam int NS = 1 + RW + NW;
  localparam longint EPS = longint'((64'd1 << F) / 64'd100000000);
  localparam logic signed [AW-1:0] ONE_A = AW'(1) << F;
  localparam logic signed [AW-1:0] EPS_A = AW'(EPS);
  localparam logic [NW-1:0] WMAX_N = NW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [NW-1:0] WNEG_N = NW'(64'd1 << (W - 1));

  typedef struct packed {
    logic [SW-1:0]          rad;
    logic [SR-1:0]          srem;
    logic [RW-1:0]          root;
    logic [1:0]             br;
    logic                   deg;
    logic [2:0]             neg;
    logic [2:0][NW-1:0]     qn;
    logic [2:0][DR-1:0]     drem;
  } stage_t;

  stage_t pipe_r [NS];
  stage_t pipe_nxt [NS];
  logic   vld_r [NS];
  logic   en;

  logic signed [W-1:0] q_x_r, q_y_r, q_z_r, q_w_r;
  logic [1:0]          br_r;
  logic                deg_r, out_vld_r;

  // The whole pipeline advances whenever the output register can take a result.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Front stage: trace, branch choice, square root argument and numerators.
  logic signed [AW-1:0] e00, e11, e22, tr, a1, a2, a3, asel;
  logic signed [W:0]    d [3];
  logic [1:0]           brc;

  function automatic logic signed [W:0] ext(input logic signed [W-1:0] v);
    ext = {v[W-1], v};
  endfunction

  function automatic logic [W:0] mag(input logic signed [W:0] v);
    mag = v[W] ? (W + 1)'(-v) : v;
  endfunction

  always_comb begin
    e00 = AW'(in_ch.m_00);
    e11 = AW'(in_ch.m_11);
    e22 = AW'(in_ch.m_22);
    tr  = ONE_A + e00 + e11 + e22;
    a1  = ONE_A + e00 - e11 - e22;
    a2  = ONE_A + e11 - e00 - e22;
    a3  = ONE_A + e22 - e00 - e11;
    if (tr > EPS_A) begin
      brc = rmq_pkg::BR_TRACE;
      asel = tr;
      d[0] = ext(in_ch.m_21) - ext(in_ch.m_12);
      d[1] = ext(in_ch.m_02) - ext(in_ch.m_20);
      d[2] = ext(in_ch.m_10) - ext(in_ch.m_01);
    end else if (in_ch.m_00 > in_ch.m_11 && in_ch.m_00 > in_ch.m_22) begin
      brc = rmq_pkg::BR_COL0;
      asel = a1;
      d[0] = ext(in_ch.m_10) + ext(in_ch.m_01);
      d[1] = ext(in_ch.m_02) + ext(in_ch.m_20);
      d[2] = ext(in_ch.m_12) - ext(in_ch.m_21);
    end else if (in_ch.m_11 > in_ch.m_22) begin
      brc = rmq_pkg::BR_COL1;
      asel = a2;
      d[0] = ext(in_ch.m_10) + ext(in_ch.m_01);
      d[1] = ext(in_ch.m_21) + ext(in_ch.m_12);
      d[2] = ext(in_ch.m_02) - ext(in_ch.m_20);
    end else begin
      brc = rmq_pkg::BR_COL2;
      asel = a3;
      d[0] = ext(in_ch.m_02) + ext(in_ch.m_20);
      d[1] = ext(in_ch.m_21) + ext(in_ch.m_12);
      d[2] = ext(in_ch.m_01) - ext(in_ch.m_10);
    end
  end

  // One square root digit per stage, then one quotient bit per stage.
  function automatic stage_t sqrt_step(input stage_t s);
    stage_t              o;
    logic [SR+1:0]       t, trial;
    o     = s;
    t     = {s.srem, s.rad[SW-1 -: 2]};
    trial = (SR + 2)'({s.root, 2'b01});
    o.rad = s.rad << 2;
    if (t >= trial) begin
      o.srem = SR'(t - trial);
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.srem = SR'(t);
      o.root = {s.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic stage_t div_step(input stage_t s);
    stage_t        o;
    logic [DR:0]   t, den;
    o   = s;
    den = (DR + 1)'({s.root, 1'b0});
    for (int k = 0; k < 3; k++) begin
      t = {s.drem[k], s.qn[k][NW-1]};
      if (t >= den) begin
        o.drem[k] = DR'(t - den);
        o.qn[k]   = {s.qn[k][NW-2:0], 1'b1};
      end else begin
        o.drem[k] = DR'(t);
        o.qn[k]   = {s.qn[k][NW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    pipe_nxt[0].rad  = (asel > 0) ? SW'({asel[AW-2:0], F'(0)}) : '0;
    pipe_nxt[0].srem = '0;
    pipe_nxt[0].root = '0;
    pipe_nxt[0].br   = brc;
    pipe_nxt[0].deg  = !(asel > 0);
    for (int k = 0; k < 3; k++) begin
      pipe_nxt[0].neg[k]  = d[k][W];
      pipe_nxt[0].qn[k]   = {mag(d[k]), F'(0)};
      pipe_nxt[0].drem[k] = '0;
    end
    for (int i = 1; i < NS; i++) begin
      if (i <= RW) pipe_nxt[i] = sqrt_step(pipe_r[i-1]);
      else         pipe_nxt[i] = div_step(pipe_r[i-1]);
    end
  end

  // Pipeline registers; valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) pipe_r[i] <= pipe_nxt[i];
    end
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Saturation and placement of the diagonal and off-diagonal components.
  function automatic logic signed [W-1:0] sat_q(input logic [NW-1:0] q, input logic n);
    if (!n) sat_q = (q > WMAX_N) ? W'(WMAX_N) : W'(q);
    else    sat_q = (q > WNEG_N) ? W'(WNEG_N) : W'(-q);
  endfunction

  stage_t              last;
  logic signed [W-1:0] dg, o0, o1, o2;
  logic signed [W-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;

  always_comb begin
    last = pipe_r[NS-1];
    dg = sat_q(NW'(last.root >> 1), 1'b0);
    o0 = sat_q(last.qn[0], last.neg[0]);
    o1 = sat_q(last.qn[1], last.neg[1]);
    o2 = sat_q(last.qn[2], last.neg[2]);
    unique case (last.br)
      rmq_pkg::BR_TRACE: begin qx_nxt = o0; qy_nxt = o1; qz_nxt = o2; qw_nxt = dg; end
      rmq_pkg::BR_COL0:  begin qx_nxt = dg; qy_nxt = o0; qz_nxt = o1; qw_nxt = o2; end
      rmq_pkg::BR_COL1:  begin qx_nxt = o0; qy_nxt = dg; qz_nxt = o1; qw_nxt = o2; end
      default:           begin qx_nxt = o0; qy_nxt = o1; qz_nxt = dg; qw_nxt = o2; end
    endcase
    if (last.deg) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      q_x_r <= qx_nxt;
      q_y_r <= qy_nxt;
      q_z_r <= qz_nxt;
      q_w_r <= qw_nxt;
      br_r  <= last.br;
      deg_r <= last.deg;
    end
    if (!rst_n)  out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_r[NS-1];
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.q_x          = q_x_r;
  assign out_ch.q_y          = q_y_r;
  assign out_ch.q_z          = q_z_r;
  assign out_ch.q_w          = q_w_r;
  assign out_ch.branch_taken = br_r;
  assign out_ch.degenerate   = deg_r;

  // A degenerate result carries an all-zero quaternion.
  `RMQ_ASSERT_NOW(a_deg_zero, out_vld_r && deg_r, (q_x_r | q_y_r | q_z_r | q_w_r) == '0)
  // The trace path always has a positive square root argument.
  `RMQ_ASSERT_NOW(a_trace_ok, out_vld_r && br_r == rmq_pkg::BR_TRACE, !deg_r)
  // An empty output register never holds back the input.
  `RMQ_ASSERT_NOW(a_ready, !out_vld_r, in_ch.ready)
  // A stalled result lets no new result in behind it.
  `RMQ_ASSERT_NEXT(a_hold, out_vld_r && !out_ch.ready, out_vld_r && $stable(br_r))
endmodule

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
// Self-checking testbench for the rotation matrix to quaternion converter.
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = rmq_pkg::WORD_BITS_DEF;
  localparam int FB = rmq_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1500;
  localparam logic signed [WB-1:0] ONE_RAW = 16'sd16384;
  localparam logic signed [WB-1:0] MAX_RAW = 16'sh7fff;
  localparam logic signed [WB-1:0] MIN_RAW = 16'sh8000;

  typedef logic signed [WB-1:0] word_t;
  typedef struct packed {
    word_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;
  typedef struct packed {
    word_t qx, qy, qz, qw;
    logic [1:0] br;
    logic deg;
  } quat_t;
  typedef struct {
    matrix_t m;
    logic has_quat;
    quat_t q;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int errors = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;
  quat_t expected_quats[$];
  vector_t directed[$];

  rmq_in_if  #(.WORD_BITS(WB)) in_ch ();
  rmq_out_if #(.WORD_BITS(WB)) out_ch ();

  rotation_matrix_to_quaternion #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // Saturate a wide value to the signed output word.
  function automatic word_t clip(longint v);
    if (v > 32767) return MAX_RAW;
    if (v < -32768) return MIN_RAW;
    return word_t'(v);
  endfunction

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Off-diagonal component: (d << FB) / (2r), truncated toward zero.
  function automatic word_t scaled_quot(longint d, longint unsigned r);
    longint unsigned mag = (d < 0) ? longint'(-d) : d;
    longint q = longint'((mag << FB) / (r * 2));
    return clip(d < 0 ? -q : q);
  endfunction

  // Quaternion predicted for one matrix.
  function automatic quat_t matrix_to_quat(matrix_t m);
    quat_t q = '0;
    longint a00 = m.m00, a01 = m.m01, a02 = m.m02;
    longint a10 = m.m10, a11 = m.m11, a12 = m.m12;
    longint a20 = m.m20, a21 = m.m21, a22 = m.m22;
    longint one = 64'sd1 << FB;
    longint eps = one / 100000000;
    longint tr = one + a00 + a11 + a22;
    longint arg;
    longint unsigned r;
    word_t diag;
    if (tr > eps) begin
      q.br = rmq_pkg::BR_TRACE; arg = tr;
    end else if (a00 > a11 && a00 > a22) begin
      q.br = rmq_pkg::BR_COL0; arg = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      q.br = rmq_pkg::BR_COL1; arg = one + a11 - a00 - a22;
    end else begin
      q.br = rmq_pkg::BR_COL2; arg = one + a22 - a00 - a11;
    end
    if (arg <= 0) begin
      q.deg = 1'b1;
      return q;
    end
    r = int_sqrt(longint'(arg) << FB);
    diag = clip(longint'(r >> 1));
    case (q.br)
      rmq_pkg::BR_TRACE: begin
        q.qx = scaled_quot(a21 - a12, r); q.qy = scaled_quot(a02 - a20, r);
        q.qz = scaled_quot(a10 - a01, r); q.qw = diag;
      end
      rmq_pkg::BR_COL0: begin
        q.qx = diag; q.qy = scaled_quot(a10 + a01, r);
        q.qz = scaled_quot(a02 + a20, r); q.qw = scaled_quot(a12 - a21, r);
      end
      rmq_pkg::BR_COL1: begin
        q.qx = scaled_quot(a10 + a01, r); q.qy = diag;
        q.qz = scaled_quot(a21 + a12, r); q.qw = scaled_quot(a02 - a20, r);
      end
      default: begin
        q.qx = scaled_quot(a02 + a20, r); q.qy = scaled_quot(a21 + a12, r);
        q.qz = diag; q.qw = scaled_quot(a01 - a10, r);
      end
    endcase
    return q;
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  function automatic word_t near(int base, int span);
    return clip(base + $signed($urandom_range(2 * span)) - span);
  endfunction

  // Near-rotation matrix: a signed permutation with small noise, which reaches
  // every branch and keeps most results in range.
  function automatic matrix_t random_rotation();
    matrix_t m;
    word_t e[9];
    int p[3];
    int s[3];
    int k;
    int span = ($urandom_range(3) == 0) ? 8000 : 600;
    p[0] = $urandom_range(2);
    p[1] = (p[0] + 1 + $urandom_range(1)) % 3;
    p[2] = 3 - p[0] - p[1];
    for (int i = 0; i < 3; i++) s[i] = $urandom_range(1) ? 1 : -1;
    for (int i = 0; i < 9; i++) begin
      k = (p[i / 3] == i % 3) ? s[i / 3] * 16384 : 0;
      e[i] = near(k, span);
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    if ($urandom_range(9) < 7) return random_rotation();
    m = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word(), rand_word(), rand_word(), rand_word()};
    return m;
  endfunction

  function automatic quat_t q_of(word_t x, word_t y, word_t z, word_t w, logic [1:0] b,
                                 logic d);
    quat_t q;
    q.qx = x; q.qy = y; q.qz = z; q.qw = w; q.br = b; q.deg = d;
    return q;
  endfunction

  function automatic void add_row(matrix_t m, logic known, quat_t q);
    vector_t v;
    v.m = m; v.has_quat = known; v.q = q;
    directed.push_back(v);
  endfunction

  // Directed table: identity, extremes, ties and each branch.
  initial begin
    add_row({ONE_RAW, 16'sd0, 16'sd0, 16'sd0, ONE_RAW, 16'sd0, 16'sd0, 16'sd0, ONE_RAW},
            1'b1, q_of(0, 0, 0, 16'sd16384, rmq_pkg::BR_TRACE, 1'b0));
    add_row('0, 1'b1, q_of(0, 0, 0, 16'sd8192, rmq_pkg::BR_TRACE, 1'b0));
    // All elements at the negative extreme: the three-way tie picks column 2.
    add_row({9{MIN_RAW}}, 1'b0, '0);
    add_row({9{MAX_RAW}}, 1'b0, '0);
    add_row({9{16'sh5555}}, 1'b0, '0);
    add_row({9{16'shaaaa}}, 1'b0, '0);
    add_row({ONE_RAW, 16'sd0, 16'sd0, 16'sd0, -ONE_RAW, 16'sd0, 16'sd0, 16'sd0, -ONE_RAW},
            1'b1, q_of(16'sd16384, 0, 0, 0, rmq_pkg::BR_COL0, 1'b0));
    add_row({-ONE_RAW, 16'sd0, 16'sd0, 16'sd0, ONE_RAW, 16'sd0, 16'sd0, 16'sd0, -ONE_RAW},
            1'b1, q_of(0, 16'sd16384, 0, 0, rmq_pkg::BR_COL1, 1'b0));
    add_row({-ONE_RAW, 16'sd0, 16'sd0, 16'sd0, -ONE_RAW, 16'sd0, 16'sd0, 16'sd0, ONE_RAW},
            1'b1, q_of(0, 0, 16'sd16384, 0, rmq_pkg::BR_COL2, 1'b0));
    // Trace exactly zero goes to the column branches; m00 above tied m11 and m22
    // picks column 0.
    add_row({16'sd0, 16'sd1, 16'sd2, 16'sd3, -16'sd8192, 16'sd5, 16'sd6, 16'sd7,
             -16'sd8192}, 1'b0, '0);
    // Tie m00 == m11 above m22 picks column 1.
    add_row({-16'sd4096, 16'sd100, -16'sd200, 16'sd300, -16'sd4096, 16'sd500, 16'sd600,
             -16'sd700, -16'sd9000}, 1'b0, '0);
    // Column 0 with the other two diagonal elements far below it.
    add_row({-16'sd10000, 16'sd1, 16'sd1, 16'sd1, -16'sd20000, 16'sd1, 16'sd1, 16'sd1,
             -16'sd20000}, 1'b0, '0);
    // Trace of one raw unit: tiny root, saturating quotients.
    add_row({-16'sd16383, MAX_RAW, MIN_RAW, MIN_RAW, 16'sd0, MAX_RAW, MAX_RAW, MIN_RAW,
             16'sd0}, 1'b0, '0);
    add_row({MAX_RAW, MIN_RAW, MAX_RAW, MIN_RAW, MIN_RAW, MAX_RAW, MIN_RAW, MAX_RAW,
             MIN_RAW}, 1'b0, '0);
    add_row({MIN_RAW, MAX_RAW, MIN_RAW, MAX_RAW, MAX_RAW, MIN_RAW, MAX_RAW, MIN_RAW,
             MIN_RAW}, 1'b0, '0);
    add_row({MIN_RAW, 16'sd1, -16'sd1, 16'sd77, MIN_RAW, -16'sd77, 16'sd9, -16'sd9,
             MAX_RAW}, 1'b0, '0);
  end

  // Drive one matrix and wait for its transaction; valid drops only in a gap.
  task automatic send_matrix(matrix_t m);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m_00, in_ch.m_01, in_ch.m_02, in_ch.m_10, in_ch.m_11, in_ch.m_12,
     in_ch.m_20, in_ch.m_21, in_ch.m_22} <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(m));
  endtask

  // Receiver readiness: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_quats.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_ch.q_x !== exp_q.qx) begin
          $error("q_x expected %0d actual %0d", exp_q.qx, out_ch.q_x); errors++;
        end
        if (out_ch.q_y !== exp_q.qy) begin
          $error("q_y expected %0d actual %0d", exp_q.qy, out_ch.q_y); errors++;
        end
        if (out_ch.q_z !== exp_q.qz) begin
          $error("q_z expected %0d actual %0d", exp_q.qz, out_ch.q_z); errors++;
        end
        if (out_ch.q_w !== exp_q.qw) begin
          $error("q_w expected %0d actual %0d", exp_q.qw, out_ch.q_w); errors++;
        end
        if (out_ch.branch_taken !== exp_q.br) begin
          $error("branch_taken expected %0d actual %0d", exp_q.br, out_ch.branch_taken);
          errors++;
        end
        if (out_ch.degenerate !== exp_q.deg) begin
          $error("degenerate expected %0d actual %0d", exp_q.deg, out_ch.degenerate);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    wait (sending_done == 1'b0 && rst_n);
    repeat (400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m_00, in_ch.m_01, in_ch.m_02, in_ch.m_10, in_ch.m_11, in_ch.m_12,
     in_ch.m_20, in_ch.m_21, in_ch.m_22} = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed rows; known expectations are checked against the predictor too.
    foreach (directed[i]) begin
      if (directed[i].has_quat && matrix_to_quat(directed[i].m) !== directed[i].q) begin
        $error("directed row %0d: table and predictor disagree", i);
        errors++;
      end
      send_matrix(directed[i].m);
    end
    // Random phases: none, sender gaps, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1) ? 72 : (ph == 3) ? 21 : 0;
      stall_pct = (ph == 2) ? 72 : (ph == 3) ? 21 : 0;
      for (int n = 0; n < N_RANDOM / 4; n++) send_matrix(random_matrix());
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
    gap_pct = 0;
    stall_pct = 0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
